// ----- rtl/core/mhpq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared constants and types for the max-heap priority queue core.
// ----------------------------------------------------------------------------
package mhpq_pkg;

	// heap geometry
	localparam int HEAP_DEPTH = 1024;
	localparam int ADDR_W     = $clog2(HEAP_DEPTH);
	localparam int COUNT_W    = ADDR_W + 1;
	localparam int KEY_W      = 32;

	typedef logic signed [KEY_W-1:0] key_t;
	typedef logic [ADDR_W-1:0]       addr_t;
	typedef logic [COUNT_W-1:0]      count_t;

	// command codes
	localparam logic CMD_INSERT  = 1'b0;
	localparam logic CMD_EXTRACT = 1'b1;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

endpackage
`default_nettype wire

// ----- rtl/core/mhpq_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_ram
// One write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module mhpq_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read ports
	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule
`default_nettype wire

// ----- rtl/core/max_heap_priority_queue_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// max_heap_priority_queue_core
// Binary max-heap priority queue of signed 32-bit keys held in one RAM.
// ----------------------------------------------------------------------------
// Usage:
// - A command word is taken at a rising edge with start high and busy low.
//   command selects insert of key_in or extract of the largest key.
// - Every command gives one result word: done is high for exactly one cycle
//   with max_key, status and count_after valid. The receiver cannot stall.
// - max_key is zero for inserts and errors; status flags extract while empty
//   and insert while full, and such commands leave the heap untouched.
// - Timing: the sifting key is kept in a register, and the read for each
//   heap level is issued the cycle before its compare and write-back. An
//   insert into an empty heap and the error cases never raise busy; other
//   inserts and extracts keep busy high while the key sifts. done is high
//   in the first cycle with busy low after the command, and the next command
//   may be taken in that same cycle.
// - Errors finish without raising busy.
// - Reset clears the entry count; the RAM needs no clearing since data read
//   from slots at or above the count is never used.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic                        command,
	input  wire mhpq_pkg::key_t              key_in,
	output logic                             done,
	output mhpq_pkg::key_t                   max_key,
	output logic [1:0]                       status,
	output mhpq_pkg::count_t                 count_after
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP_CMP,
		S_DN_FIRST,
		S_DN_CMP,
		S_WR_FINAL
	} state_t;

	state_t            state_q, nxt_state;
	mhpq_pkg::addr_t   pos_q, nxt_pos;
	mhpq_pkg::count_t  cnt_q, nxt_cnt;
	mhpq_pkg::key_t    key_q, nxt_key;
	mhpq_pkg::key_t    max_q, nxt_max;

	logic              done_q;
	mhpq_pkg::key_t    max_key_q;
	logic [1:0]        status_q;
	mhpq_pkg::count_t  count_after_q;

	// memory port signals
	logic              mem_we;
	mhpq_pkg::addr_t   mem_waddr;
	mhpq_pkg::key_t    mem_wdata;
	mhpq_pkg::addr_t   mem_ra;
	mhpq_pkg::addr_t   mem_rb;
	logic [mhpq_pkg::KEY_W-1:0] mem_rda_raw;
	logic [mhpq_pkg::KEY_W-1:0] mem_rdb_raw;
	mhpq_pkg::key_t    mem_rda;
	mhpq_pkg::key_t    mem_rdb;

	// result of the current cycle
	logic              fin;
	mhpq_pkg::key_t    fin_max;
	logic [1:0]        fin_status;
	mhpq_pkg::count_t  fin_count;

	// index helpers
	mhpq_pkg::addr_t   cnt_addr;
	mhpq_pkg::addr_t   up_par;
	mhpq_pkg::count_t  dn_left;
	logic              dn_right_ok;
	logic              dn_take_right;
	mhpq_pkg::key_t    dn_child_val;
	mhpq_pkg::addr_t   dn_child_addr;
	mhpq_pkg::count_t  dn_next_left;

	assign mem_rda = $signed(mem_rda_raw);
	assign mem_rdb = $signed(mem_rdb_raw);

	mhpq_ram #(
		.DEPTH (mhpq_pkg::HEAP_DEPTH),
		.WIDTH (mhpq_pkg::KEY_W)
	) u_ram (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.raddr_a (mem_ra),
		.raddr_b (mem_rb),
		.rdata_a (mem_rda_raw),
		.rdata_b (mem_rdb_raw)
	);

	// heap index arithmetic
	assign cnt_addr      = cnt_q[mhpq_pkg::ADDR_W-1:0];
	assign up_par        = (pos_q - mhpq_pkg::ADDR_W'(1)) >> 1;
	assign dn_left       = {pos_q, 1'b1};
	assign dn_right_ok   = (dn_left + mhpq_pkg::COUNT_W'(1)) < cnt_q;
	assign dn_take_right = dn_right_ok && (mem_rdb > mem_rda);
	assign dn_child_val  = dn_take_right ? mem_rdb : mem_rda;
	assign dn_child_addr = dn_take_right ? mhpq_pkg::ADDR_W'(dn_left + mhpq_pkg::COUNT_W'(1))
	                                     : dn_left[mhpq_pkg::ADDR_W-1:0];
	assign dn_next_left  = {dn_child_addr, 1'b1};

	// sequencer next-state and memory control
	always_comb begin
		nxt_state  = state_q;
		nxt_pos    = pos_q;
		nxt_cnt    = cnt_q;
		nxt_key    = key_q;
		nxt_max    = max_q;
		mem_we     = 1'b0;
		mem_waddr  = pos_q;
		mem_wdata  = key_q;
		mem_ra     = '0;
		mem_rb     = '0;
		fin        = 1'b0;
		fin_max    = '0;
		fin_status = mhpq_pkg::ST_OK;
		fin_count  = cnt_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (command == mhpq_pkg::CMD_INSERT) begin
						if (cnt_q == mhpq_pkg::COUNT_W'(mhpq_pkg::HEAP_DEPTH)) begin
							fin        = 1'b1;
							fin_status = mhpq_pkg::ST_FULL;
						end else if (cnt_q == '0) begin
							mem_we    = 1'b1;
							mem_waddr = '0;
							mem_wdata = key_in;
							nxt_cnt   = mhpq_pkg::COUNT_W'(1);
							fin       = 1'b1;
							fin_count = mhpq_pkg::COUNT_W'(1);
						end else begin
							mem_ra    = (cnt_addr - mhpq_pkg::ADDR_W'(1)) >> 1;
							nxt_pos   = cnt_addr;
							nxt_key   = key_in;
							nxt_max   = '0;
							nxt_cnt   = cnt_q + mhpq_pkg::COUNT_W'(1);
							nxt_state = S_UP_CMP;
						end
					end else begin
						if (cnt_q == '0) begin
							fin        = 1'b1;
							fin_status = mhpq_pkg::ST_EMPTY;
						end else begin
							mem_ra    = '0;
							mem_rb    = mhpq_pkg::ADDR_W'(cnt_q - mhpq_pkg::COUNT_W'(1));
							nxt_cnt   = cnt_q - mhpq_pkg::COUNT_W'(1);
							nxt_state = S_DN_FIRST;
						end
					end
				end
			end
			S_UP_CMP: begin
				// parent data is on port a
				if (key_q > mem_rda) begin
					mem_we    = 1'b1;
					mem_wdata = mem_rda;
					nxt_pos   = up_par;
					if (up_par == '0) begin
						nxt_state = S_WR_FINAL;
					end else begin
						mem_ra = (up_par - mhpq_pkg::ADDR_W'(1)) >> 1;
					end
				end else begin
					mem_we    = 1'b1;
					fin       = 1'b1;
					nxt_state = S_IDLE;
				end
			end
			S_DN_FIRST: begin
				// root on port a, last entry on port b
				nxt_max = mem_rda;
				nxt_key = mem_rdb;
				nxt_pos = '0;
				if (cnt_q == '0) begin
					fin       = 1'b1;
					fin_max   = mem_rda;
					nxt_state = S_IDLE;
				end else if (cnt_q == mhpq_pkg::COUNT_W'(1)) begin
					mem_we    = 1'b1;
					mem_waddr = '0;
					mem_wdata = mem_rdb;
					fin       = 1'b1;
					fin_max   = mem_rda;
					nxt_state = S_IDLE;
				end else begin
					mem_ra    = mhpq_pkg::ADDR_W'(1);
					mem_rb    = mhpq_pkg::ADDR_W'(2);
					nxt_state = S_DN_CMP;
				end
			end
			S_DN_CMP: begin
				// children of pos on ports a and b
				if (dn_child_val > key_q) begin
					mem_we    = 1'b1;
					mem_wdata = dn_child_val;
					nxt_pos   = dn_child_addr;
					if (dn_next_left >= cnt_q) begin
						nxt_state = S_WR_FINAL;
					end else begin
						mem_ra = dn_next_left[mhpq_pkg::ADDR_W-1:0];
						mem_rb = mhpq_pkg::ADDR_W'(dn_next_left + mhpq_pkg::COUNT_W'(1));
					end
				end else begin
					mem_we    = 1'b1;
					fin       = 1'b1;
					fin_max   = max_q;
					nxt_state = S_IDLE;
				end
			end
			S_WR_FINAL: begin
				mem_we    = 1'b1;
				fin       = 1'b1;
				fin_max   = max_q;
				nxt_state = S_IDLE;
			end
			default: begin
				nxt_state = S_IDLE;
			end
		endcase
	end

	// state and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cnt_q         <= '0;
			done_q        <= 1'b0;
			pos_q         <= '0;
			key_q         <= '0;
			max_q         <= '0;
			max_key_q     <= '0;
			status_q      <= mhpq_pkg::ST_OK;
			count_after_q <= '0;
		end else begin
			state_q <= nxt_state;
			cnt_q   <= nxt_cnt;
			pos_q   <= nxt_pos;
			key_q   <= nxt_key;
			max_q   <= nxt_max;
			done_q  <= fin;
			if (fin) begin
				max_key_q     <= fin_max;
				status_q      <= fin_status;
				count_after_q <= fin_count;
			end
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign max_key     = max_key_q;
	assign status      = status_q;
	assign count_after = count_after_q;

endmodule
`default_nettype wire

// ----- tb/tb_max_heap_priority_queue_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_max_heap_priority_queue_core
// Drives insert and extract words into the heap core and checks every result
// word against a shadow max-heap updated when each command word is accepted.
// Covers empty extracts, extreme and equal keys, a fill to capacity with
// inserts while full, and random mixes with random sender gaps.
// ----------------------------------------------------------------------------
module tb_max_heap_priority_queue_core;

	localparam mhpq_pkg::key_t KEY_MAX = 32'sh7FFF_FFFF;
	localparam mhpq_pkg::key_t KEY_MIN = 32'sh8000_0000;

	typedef struct {
		mhpq_pkg::key_t   max_key;
		logic [1:0]       status;
		mhpq_pkg::count_t count_after;
	} heap_result_t;

	// shadow heap plus the queue of result words still owed by the core
	class heap_shadow;
		mhpq_pkg::key_t slots[mhpq_pkg::HEAP_DEPTH];
		int unsigned    fill;
		heap_result_t   owed[$];
		int unsigned    errors;

		function new();
			fill   = 0;
			errors = 0;
		endfunction

		// apply one accepted command word and queue its result word
		function void take_word(logic cmd, mhpq_pkg::key_t key);
			heap_result_t   r;
			mhpq_pkg::key_t tmp;
			int unsigned    pos;
			int unsigned    kid;
			bit             moving;
			r.max_key = '0;
			r.status  = mhpq_pkg::ST_OK;
			if (cmd == mhpq_pkg::CMD_INSERT) begin
				if (fill >= mhpq_pkg::HEAP_DEPTH) begin
					r.status = mhpq_pkg::ST_FULL;
				end else begin
					pos = fill;
					slots[pos] = key;
					// rise only while strictly above the parent
					while (pos > 0 && slots[pos] > slots[(pos - 1) / 2]) begin
						tmp = slots[pos];
						slots[pos] = slots[(pos - 1) / 2];
						slots[(pos - 1) / 2] = tmp;
						pos = (pos - 1) / 2;
					end
					fill++;
				end
			end else begin
				if (fill == 0) begin
					r.status = mhpq_pkg::ST_EMPTY;
				end else begin
					r.max_key = slots[0];
					slots[0] = slots[fill - 1];
					fill--;
					pos    = 0;
					kid    = 1;
					moving = 1'b1;
					// sink toward the larger child, left one on a tie
					while (moving && kid < fill) begin
						if (kid + 1 < fill && slots[kid + 1] > slots[kid])
							kid++;
						if (slots[kid] > slots[pos]) begin
							tmp = slots[pos];
							slots[pos] = slots[kid];
							slots[kid] = tmp;
							pos = kid;
							kid = 2 * pos + 1;
						end else begin
							moving = 1'b0;
						end
					end
				end
			end
			r.count_after = mhpq_pkg::count_t'(fill);
			owed.push_back(r);
		endfunction

		// compare one result word with the oldest owed one
		function void check_word(mhpq_pkg::key_t mk, logic [1:0] st, mhpq_pkg::count_t cnt);
			heap_result_t want;
			if (owed.size() == 0) begin
				$error("result word with nothing owed: max_key %0d status %0d count_after %0d",
					mk, st, cnt);
				errors++;
				return;
			end
			want = owed.pop_front();
			if (mk !== want.max_key) begin
				$error("max_key: expected %0d, got %0d", want.max_key, mk);
				errors++;
			end
			if (st !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, st);
				errors++;
			end
			if (cnt !== want.count_after) begin
				$error("count_after: expected %0d, got %0d", want.count_after, cnt);
				errors++;
			end
		endfunction
	endclass

	logic             clk     = 1'b0;
	logic             arst_n  = 1'b0;
	logic             start   = 1'b0;
	logic             command = mhpq_pkg::CMD_INSERT;
	mhpq_pkg::key_t   key_in  = '0;
	logic             busy;
	logic             done;
	mhpq_pkg::key_t   max_key;
	logic [1:0]       status;
	mhpq_pkg::count_t count_after;

	heap_shadow shadow;
	bit         steady = 1'b0;

	max_heap_priority_queue_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.command     (command),
		.key_in      (key_in),
		.done        (done),
		.max_key     (max_key),
		.status      (status),
		.count_after (count_after)
	);

	// clock
	always #2 clk = ~clk;

	// result words are taken on the edge that ends their strobe cycle
	always @(posedge clk) begin
		if (arst_n && done)
			shadow.check_word(max_key, status, count_after);
	end

	// keys biased toward ties, sign flips and the range ends
	function automatic mhpq_pkg::key_t pick_key();
		case ($urandom_range(0, 9))
			5, 6, 7: pick_key = mhpq_pkg::key_t'(int'($urandom_range(0, 8)) - 4);
			8:       pick_key = $urandom_range(0, 1) ? KEY_MAX : KEY_MIN;
			9:       pick_key = $urandom_range(0, 1)
				? KEY_MAX - mhpq_pkg::key_t'($urandom_range(0, 3))
				: KEY_MIN + mhpq_pkg::key_t'($urandom_range(0, 3));
			default: pick_key = mhpq_pkg::key_t'($urandom);
		endcase
	endfunction

	// hand one command word over, then maybe leave a gap
	task automatic send_word(logic cmd, mhpq_pkg::key_t key);
		start   <= 1'b1;
		command <= cmd;
		key_in  <= key;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		shadow.take_word(cmd, key);
		if (!steady && $urandom_range(0, 99) < 10) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 14))
				@(posedge clk);
		end
	endtask

	task automatic send_random(int unsigned insert_pct);
		send_word(($urandom_range(0, 99) < insert_pct) ? mhpq_pkg::CMD_INSERT
			: mhpq_pkg::CMD_EXTRACT, pick_key());
	endtask

	// hold the sender off until every owed result word is back
	task automatic wait_owed_clear();
		start <= 1'b0;
		while (shadow.owed.size() != 0)
			@(posedge clk);
	endtask

	// stimulus
	initial begin
		int i;
		shadow = new();
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extract on an empty heap, then extremes, ties and bit patterns
		send_word(mhpq_pkg::CMD_EXTRACT, mhpq_pkg::key_t'($urandom));
		send_word(mhpq_pkg::CMD_INSERT, KEY_MIN);
		send_word(mhpq_pkg::CMD_INSERT, KEY_MAX);
		send_word(mhpq_pkg::CMD_INSERT, 32'sd0);
		send_word(mhpq_pkg::CMD_INSERT, -32'sd1);
		send_word(mhpq_pkg::CMD_INSERT, 32'sd1);
		send_word(mhpq_pkg::CMD_INSERT, 32'sd7);
		send_word(mhpq_pkg::CMD_INSERT, 32'sd7);
		send_word(mhpq_pkg::CMD_INSERT, 32'sd7);
		send_word(mhpq_pkg::CMD_INSERT, 32'shAAAA_AAAA);
		send_word(mhpq_pkg::CMD_INSERT, 32'sh5555_5555);
		send_word(mhpq_pkg::CMD_INSERT, KEY_MAX);
		// drain everything and one extract past empty
		for (i = 0; i < 12; i++)
			send_word(mhpq_pkg::CMD_EXTRACT, mhpq_pkg::key_t'($urandom));
		wait_owed_clear();

		// balanced mix around a nearly empty heap
		for (i = 0; i < 100; i++)
			send_random(50);

		// fill to capacity, back to back through the middle
		while (shadow.fill < mhpq_pkg::HEAP_DEPTH) begin
			steady = (shadow.fill >= 200 && shadow.fill < 600);
			send_random(95);
		end
		steady = 1'b0;

		// hammer the full heap
		for (i = 0; i < 20; i++)
			send_random(60);
		wait_owed_clear();

		// balanced mix near capacity, deep sifts both ways
		for (i = 0; i < 100; i++)
			send_random(50);

		wait_owed_clear();
		repeat (30)
			@(posedge clk);
		if (shadow.errors == 0)
			$display("tb_max_heap_priority_queue_core OK");
		else
			$display("tb_max_heap_priority_queue_core NOT OK");
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("tb_max_heap_priority_queue_core NOT OK");
		$finish;
	end

endmodule
